[rtl/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the coordinate chord unit: Q16.16 limits,
// divider step count and the command/status groups between control and data.
// ----------------------------------------------------------------------------
package pcc_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned DIV_STEPS = 33;
	localparam int unsigned CNT_W     = 6;

	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_COLUMN = 1'b1;

	typedef struct packed {
		logic accept;
		logic load_mag;
		logic load_div;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic bypass;
		logic div_last;
		logic last;
		logic out_free;
	} sts_t;

endpackage

[rtl/pcc_ctrl.sv]
// ----------------------------------------------------------------------------
// pcc_ctrl
// Sequencer of the chord unit: takes a beat, walks a column entry through
// operand fetch, divider setup, quotient iterations unless bypassed, bound update.
// ----------------------------------------------------------------------------
module pcc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          action,
	output logic          in_stall,
	input  pcc_pkg::sts_t sts,
	output pcc_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_SETUP  = 5'b00100,
		ST_DIVIDE = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.accept   = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && action == pcc_pkg::ACT_COLUMN) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.load_mag = 1'b1;
				state_d      = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.load_div = 1'b1;
				state_d      = sts.bypass ? ST_FINISH : ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold while a finished beat still waits at the output
				if (!sts.last || sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/pcc_datapath.sv]
// ----------------------------------------------------------------------------
// pcc_datapath
// Slack memory, radix-2 restoring divider for (s << 16) / a with early
// saturation detect, bound accumulators and the output register.
// ----------------------------------------------------------------------------
module pcc_datapath #(
	parameter int unsigned ROWS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pcc_pkg::cmd_t       cmd,
	output pcc_pkg::sts_t       sts,
	input  logic                action,
	input  logic [9:0]          row,
	input  logic signed [31:0]  value,
	input  logic                last,
	input  logic                out_stall,
	output logic                out_valid,
	output logic signed [31:0]  t_low,
	output logic signed [31:0]  t_high
);

	localparam int unsigned AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned EXT_W = (AW > 10) ? AW : 10;
	localparam int unsigned CMP_W = 17;

	logic signed [31:0] mem [ROWS];

	logic [EXT_W-1:0] row_ext;
	logic [AW-1:0]    addr;
	logic             in_range;

	logic signed [31:0] s_rd_q;
	logic               range_q;
	logic signed [31:0] a_q;
	logic               last_q;

	logic signed [31:0] s_eff;
	logic [31:0]        s_mag_q, a_mag_q;
	logic               s_neg_q, a_neg_q, a_zero_q;
	logic               ovf;
	logic               ovf_q;

	logic [31:0]               rem_q;
	logic [32:0]               nbits_q;
	logic [32:0]               quot_q;
	logic [pcc_pkg::CNT_W-1:0] cnt_q;
	logic [32:0]               trial;
	logic [32:0]               diff;
	logic                      qbit;

	logic               q_neg;
	logic [31:0]        q_lo;
	logic signed [31:0] t_val;
	logic signed [31:0] low_q, high_q;
	logic signed [31:0] low_new, high_new;
	logic               out_valid_q;
	logic signed [31:0] t_low_q, t_high_q;

	assign row_ext  = EXT_W'(row);
	assign addr     = row_ext[AW-1:0];
	assign in_range = CMP_W'(row) < CMP_W'(ROWS);

	// slack memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.accept && action == pcc_pkg::ACT_WRITE && in_range) begin
			mem[addr] <= value;
		end
		if (cmd.accept && action == pcc_pkg::ACT_COLUMN) begin
			s_rd_q  <= mem[addr];
			range_q <= in_range;
			a_q     <= value;
			last_q  <= last;
		end
	end

	assign s_eff = range_q ? s_rd_q : 32'sd0;

	always_ff @(posedge clk) begin
		if (cmd.load_mag) begin
			s_neg_q  <= s_eff[31];
			a_neg_q  <= a_q[31];
			a_zero_q <= (a_q == 32'sd0);
			s_mag_q  <= s_eff[31] ? (~s_eff + 32'd1) : s_eff;
			a_mag_q  <= a_q[31] ? (~a_q + 32'd1) : a_q;
		end
	end

	// quotient needs more than 33 bits exactly when |s| >= |a| << 17
	assign ovf = {17'd0, s_mag_q} >= {a_mag_q, 17'd0};

	assign trial = {rem_q, nbits_q[32]};
	assign diff  = trial - {1'b0, a_mag_q};
	assign qbit  = (trial >= {1'b0, a_mag_q});

	always_ff @(posedge clk) begin
		if (cmd.load_div) begin
			ovf_q   <= ovf;
			rem_q   <= {17'd0, s_mag_q[31:17]};
			nbits_q <= {s_mag_q[16:0], 16'd0};
			quot_q  <= '0;
		end else if (cmd.step) begin
			rem_q   <= qbit ? diff[31:0] : trial[31:0];
			nbits_q <= {nbits_q[31:0], 1'b0};
			quot_q  <= {quot_q[31:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_div) begin
			cnt_q <= pcc_pkg::CNT_W'(pcc_pkg::DIV_STEPS);
		end else if (cmd.step) begin
			cnt_q <= cnt_q - pcc_pkg::CNT_W'(1);
		end
	end

	// sign, saturation and special cases of the quotient
	assign q_neg = s_neg_q ^ a_neg_q;
	assign q_lo  = quot_q[31:0];

	always_comb begin
		priority if (a_zero_q) begin
			t_val = s_neg_q ? pcc_pkg::Q_MIN : pcc_pkg::Q_MAX;
		end else if (ovf_q) begin
			t_val = q_neg ? pcc_pkg::Q_MIN : pcc_pkg::Q_MAX;
		end else if (q_neg && (quot_q > 33'h0_8000_0000)) begin
			t_val = pcc_pkg::Q_MIN;
		end else if (!q_neg && (quot_q > 33'h0_7FFF_FFFF)) begin
			t_val = pcc_pkg::Q_MAX;
		end else begin
			t_val = q_neg ? signed'(~q_lo + 32'd1) : signed'(q_lo);
		end
	end

	always_comb begin
		low_new  = low_q;
		high_new = high_q;
		if (a_neg_q) begin
			if (t_val > low_q) begin
				low_new = t_val;
			end
		end else begin
			if (t_val < high_q) begin
				high_new = t_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= pcc_pkg::Q_MIN;
			high_q <= pcc_pkg::Q_MAX;
		end else if (cmd.finish) begin
			low_q  <= last_q ? pcc_pkg::Q_MIN : low_new;
			high_q <= last_q ? pcc_pkg::Q_MAX : high_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish && last_q) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && last_q) begin
			t_low_q  <= low_new;
			t_high_q <= high_new;
		end
	end

	assign sts.bypass   = a_zero_q || ovf;
	assign sts.div_last = (cnt_q == pcc_pkg::CNT_W'(1));
	assign sts.last     = last_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign t_low     = t_low_q;
	assign t_high    = t_high_q;

endmodule

[rtl/polytope_coordinate_chord_unit.sv]
// A slack write leaves the unit idle; the next beat is accepted in the following cycle.
// From accept to the next accept a column entry passes slack fetch, divider setup,
// 33 restoring quotient steps in the shared divider and the bound update.
// Zero coefficients and quotients of 2^33 or more skip the divider.
// The result follows the last entry's update; a stalled result delays the next such update.
// Reset clears control, counters, accumulators and output valid; slack memory keeps garbage.
// ----------------------------------------------------------------------------
// polytope_coordinate_chord_unit
// Chord of a polytope along one coordinate axis from slack entries and a
// streamed sparse column, Q16.16 arithmetic with saturated quotients.
// ----------------------------------------------------------------------------
module polytope_coordinate_chord_unit #(
	parameter int unsigned ROWS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [9:0]         row,
	input  logic signed [31:0] value,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] t_low,
	output logic signed [31:0] t_high
);

	pcc_pkg::cmd_t cmd;
	pcc_pkg::sts_t sts;

	pcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcc_datapath #(
		.ROWS (ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.action    (action),
		.row       (row),
		.value     (value),
		.last      (last),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.t_low     (t_low),
		.t_high    (t_high)
	);

endmodule

[rtl/pcc_checker.sv]
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the chord unit, bound to the top level.
// ----------------------------------------------------------------------------
module pcc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               action,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] t_low,
	input logic signed [31:0] t_high
);

	// a stalled result beat stays offered
	a_out_hold : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(t_low) && $stable(t_high))
		else $error("result beat changed while stalled");

	// a column entry occupies the divider
	a_col_busy : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == pcc_pkg::ACT_COLUMN |=> in_stall)
		else $error("column beat did not stall input");

	a_write_fast : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == pcc_pkg::ACT_WRITE |=> !in_stall)
		else $error("slack write did not complete in one cycle");

	// a new result only comes out of column processing
	a_out_source : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without column processing");

endmodule

bind polytope_coordinate_chord_unit pcc_checker u_pcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.action    (action),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.t_low     (t_low),
	.t_high    (t_high)
);
